### rtl/erle_pkg.sv
// Shared constants, types and saturation helpers for the resonator/echo block.
package erle_pkg;

  localparam int ECHO_DEPTH = 4096;
  localparam int SAMPLE_W   = 16;
  localparam int ADDR_W     = $clog2(ECHO_DEPTH);
  localparam int LEN_W      = ADDR_W + 1;
  localparam int STATE_W    = 32;
  localparam int COEF_W     = 16;
  localparam int OPA_W      = STATE_W + 1;
  localparam int PROD_W     = OPA_W + COEF_W + 1;
  localparam int SHIFT_W    = PROD_W - COEF_W;
  localparam int ACC_W      = 36;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPRING = 3'd0,
    REG_KEEP   = 3'd1,
    REG_ALPHA  = 3'd2,
    REG_EGAIN  = 3'd3,
    REG_ELEN   = 3'd4
  } reg_idx_e;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SPRING,
    ST_VEL,
    ST_KEEP,
    ST_POS,
    ST_ALPHA,
    ST_SMOOTH,
    ST_ECHO,
    ST_OUT
  } state_e;

  typedef logic signed [STATE_W-1:0]  state_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ACC_W-1:0]    acc_t;

  // Clamp a wide sum to the signed state range
  function automatic state_t sat_state(acc_t x);
    acc_t hi;
    acc_t lo;
    hi = ACC_W'({1'b0, {(STATE_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (x > hi) begin
      sat_state = {1'b0, {(STATE_W-1){1'b1}}};
    end else if (x < lo) begin
      sat_state = {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      sat_state = x[STATE_W-1:0];
    end
  endfunction

  // Clamp a wide sum to the signed sample range
  function automatic sample_t sat_sample(acc_t x);
    acc_t hi;
    acc_t lo;
    hi = ACC_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
    lo = -hi - ACC_W'(1);
    if (x > hi) begin
      sat_sample = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end else if (x < lo) begin
      sat_sample = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      sat_sample = x[SAMPLE_W-1:0];
    end
  endfunction

endpackage

### rtl/exhaust_resonator_lowpass_echo.sv
// An accepted beat passes the sequencer states SPRING through ECHO, and its result is
// registered to sample_out_o on leaving OUT. One sample is in work at a time, as the
//   sequencer shares one multiplier over four products and the echo RAM read/write.
// An input beat is taken while the previous result still waits in the output register.
// Reset: control/config registers take defaults, then a clearing pass zeroes the echo
//   4096-word RAM, during which no input beat is accepted (config writes are).
module exhaust_resonator_lowpass_echo
  import erle_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [SAMPLE_W-1:0]   sample_in_i,
  input  logic                  sample_in_valid_i,
  output logic                  sample_in_ready_o,
  output logic [SAMPLE_W-1:0]   sample_out_o,
  output logic                  sample_out_valid_o,
  input  logic                  sample_out_ready_i
);

  // Configuration registers
  logic [COEF_W-1:0] spring_q, keep_q, alpha_q, egain_q;
  logic [LEN_W-1:0]  elen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      spring_q <= COEF_W'(1024);
      keep_q   <= COEF_W'(62259);
      alpha_q  <= COEF_W'(65535);
      egain_q  <= COEF_W'(16384);
      elen_q   <= LEN_W'(1024);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SPRING: spring_q <= cfg_data_i[COEF_W-1:0];
        REG_KEEP:   keep_q   <= cfg_data_i[COEF_W-1:0];
        REG_ALPHA:  alpha_q  <= cfg_data_i[COEF_W-1:0];
        REG_EGAIN:  egain_q  <= cfg_data_i[COEF_W-1:0];
        REG_ELEN:   elen_q   <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic   accept;
  logic   out_adv;
  logic   clr_done;

  logic [ADDR_W-1:0] clr_q;
  logic [ADDR_W-1:0] ptr_q;
  sample_t           x_q;
  sample_t           delayed_q;
  state_t            vel_q, pos_q, sm_q;
  logic signed [PROD_W-1:0] prod_q;
  sample_t           out_q;
  logic              out_valid_q;

  assign accept   = sample_in_valid_i && sample_in_ready_o;
  assign out_adv  = !out_valid_q || sample_out_ready_i;
  assign clr_done = (clr_q == ADDR_W'(ECHO_DEPTH - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR:  if (clr_done) state_d = ST_IDLE;
      ST_IDLE:   if (accept) state_d = ST_SPRING;
      ST_SPRING: state_d = ST_VEL;
      ST_VEL:    state_d = ST_KEEP;
      ST_KEEP:   state_d = ST_POS;
      ST_POS:    state_d = ST_ALPHA;
      ST_ALPHA:  state_d = ST_SMOOTH;
      ST_SMOOTH: state_d = ST_ECHO;
      ST_ECHO:   state_d = ST_OUT;
      ST_OUT:    if (out_adv) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs: handshake, multiplier operands, RAM controls
  logic signed [OPA_W-1:0] op_a;
  logic [COEF_W-1:0]       op_c;
  logic                    ram_we;
  logic                    load_prod;

  always_comb begin
    sample_in_ready_o = 1'b0;
    op_a      = '0;
    op_c      = '0;
    ram_we    = 1'b0;
    load_prod = 1'b0;
    unique case (state_q)
      ST_CLEAR: ram_we = 1'b1;
      ST_IDLE:  sample_in_ready_o = 1'b1;
      ST_SPRING: begin
        op_a = OPA_W'(x_q) - OPA_W'(pos_q);
        op_c = spring_q;
        load_prod = 1'b1;
      end
      ST_KEEP: begin
        op_a = OPA_W'(vel_q);
        op_c = keep_q;
        load_prod = 1'b1;
      end
      ST_ALPHA: begin
        op_a = OPA_W'(pos_q) - OPA_W'(sm_q);
        op_c = alpha_q;
        load_prod = 1'b1;
      end
      ST_ECHO: begin
        op_a = OPA_W'(delayed_q);
        op_c = egain_q;
        load_prod = 1'b1;
      end
      ST_OUT: ram_we = out_adv;
      default: ;
    endcase
  end

  // Shared multiplier and the floor-shifted product
  logic signed [PROD_W-1:0]  prod_d;
  logic signed [SHIFT_W-1:0] prod_sh;
  state_t vel_new;

  assign prod_d  = op_a * $signed({1'b0, op_c});
  assign prod_sh = prod_q[PROD_W-1:COEF_W];
  assign vel_new = sat_state(ACC_W'(prod_sh));

  // Echo pointer wrap with the length clamped to 1..depth
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  ptr_inc;
  logic [ADDR_W-1:0] ptr_next;

  always_comb begin
    priority if (elen_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (elen_q > LEN_W'(ECHO_DEPTH)) begin
      len_eff = LEN_W'(ECHO_DEPTH);
    end else begin
      len_eff = elen_q;
    end
    ptr_inc  = LEN_W'(ptr_q) + LEN_W'(1);
    ptr_next = (ptr_inc >= len_eff) ? '0 : ptr_inc[ADDR_W-1:0];
  end

  // Echo RAM: clear sweep, read at accept, write back at output
  logic [ADDR_W-1:0]   ram_waddr;
  logic [SAMPLE_W-1:0] ram_wdata;
  logic [SAMPLE_W-1:0] ram_rdata;

  assign ram_waddr = (state_q == ST_CLEAR) ? clr_q : ptr_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : sat_sample(ACC_W'(sm_q));

  erle_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (ECHO_DEPTH)
  ) u_echo_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      ptr_q       <= '0;
      vel_q       <= '0;
      pos_q       <= '0;
      sm_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + ADDR_W'(1);
      end
      if (state_q == ST_VEL) begin
        vel_q <= sat_state(ACC_W'(vel_q) + ACC_W'(prod_sh));
      end
      if (state_q == ST_POS) begin
        vel_q <= vel_new;
        pos_q <= sat_state(ACC_W'(pos_q) + ACC_W'(vel_new));
      end
      if (state_q == ST_SMOOTH) begin
        sm_q <= sat_state(ACC_W'(sm_q) + ACC_W'(prod_sh));
      end
      // Hand the result to the output register, drop it once taken
      if (state_q == ST_OUT && out_adv) begin
        ptr_q       <= ptr_next;
        out_valid_q <= 1'b1;
      end else if (sample_out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= sample_in_i;
    end
    if (state_q == ST_SPRING) begin
      delayed_q <= ram_rdata;
    end
    if (load_prod) begin
      prod_q <= prod_d;
    end
    if (state_q == ST_OUT && out_adv) begin
      out_q <= sat_sample(ACC_W'(sm_q) + ACC_W'(prod_sh));
    end
  end

  assign sample_out_o       = out_q;
  assign sample_out_valid_o = out_valid_q;

endmodule

### rtl/erle_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module erle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/erle_checker.sv
// Port-level checker for the resonator/echo block, bound to the top level.
module erle_checker
  import erle_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  sample_in_valid_i,
  input logic                  sample_in_ready_o,
  input logic [SAMPLE_W-1:0]   sample_out_o,
  input logic                  sample_out_valid_o,
  input logic                  sample_out_ready_i
);

  logic in_beat;
  assign in_beat = sample_in_valid_i && sample_in_ready_o;

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_out_valid_o && !sample_out_ready_i |=> sample_out_valid_o && $stable(sample_out_o))
    else $error("result beat changed while stalled");

  // Take one sample at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !sample_in_ready_o)
    else $error("input accepted again while a sample is in work");

  // Never produce a result in the cycle right after an input beat
  a_no_early_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !$rose(sample_out_valid_o))
    else $error("result appeared too early");

  // A new result only arrives while the input side is closed
  a_out_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(sample_out_valid_o) |-> $past(!sample_in_ready_o))
    else $error("result produced while idle");

endmodule

bind exhaust_resonator_lowpass_echo erle_checker u_erle_checker (.*);
